FILE: design/dtq_pkg.sv
`timescale 1ns / 1ps

package dtq_pkg;

  localparam int NUM_JOBS_DEF  = 16;
  localparam int TIME_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_BUSY      = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_UNKNOWN   = 3'd3,
    KIND_FIRED     = 3'd4
  } kind_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  job_id;
    logic [31:0] deadline;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [3:0] event_id;
    logic       is_last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic pass_clear;
    logic fire;
  } dtq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic found;
    logic last;
  } dtq_status_t;

endpackage

FILE: design/deadline_timer_queue_core.sv
`timescale 1ns / 1ps
// Add and cancel: one result the next cycle; start is taken every cycle while busy is low.
// Tick: busy for one scan pass (scan, wait, decide) per fired job (one pass if none due),
//   set by the single read port of the deadline RAM; each fire shows the cycle after its pass.
// Results are one-cycle strobes on out_valid; the receiver cannot stall.
// Synchronous active-low reset empties the job table; the deadline RAM is not cleared.

module deadline_timer_queue_core import dtq_pkg::*; #(
  parameter int NUM_JOBS  = NUM_JOBS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int IDX_W = $clog2(NUM_JOBS);

  dtq_cmd_t         cmd;
  dtq_status_t      status;
  logic [IDX_W-1:0] rd_idx;

  dtq_ctrl #(
    .NUM_JOBS (NUM_JOBS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_data.operation),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd),
    .rd_idx    (rd_idx)
  );

  dtq_datapath #(
    .NUM_JOBS  (NUM_JOBS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .rd_idx    (rd_idx),
    .in_data   (in_data),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: design/dtq_ram.sv
`timescale 1ns / 1ps

module dtq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/dtq_ctrl.sv
`timescale 1ns / 1ps

module dtq_ctrl import dtq_pkg::*; #(
  parameter int NUM_JOBS = NUM_JOBS_DEF,
  localparam int IDX_W = $clog2(NUM_JOBS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        operation,
  input  dtq_status_t       status,
  output logic              busy,
  output dtq_cmd_t          cmd,
  output logic [IDX_W-1:0]  rd_idx
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_WAIT   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              accept;
  logic              tick_accept;

  assign busy        = (state_r != S_IDLE);
  assign accept      = start && !busy;
  assign tick_accept = accept && (operation == OP_TICK);

  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    cmd.accept     = accept;
    cmd.rd_en      = 1'b0;
    cmd.pass_clear = 1'b0;
    cmd.fire       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (tick_accept) begin
          state_nxt      = S_SCAN;
          rd_idx_nxt     = '0;
          cmd.pass_clear = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.rd_en  = 1'b1;
        rd_idx_nxt = rd_idx_r + 1'b1;
        if (rd_idx_r == IDX_W'(NUM_JOBS - 1)) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!status.found) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.fire = 1'b1;
          if (status.last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt      = S_SCAN;
            rd_idx_nxt     = '0;
            cmd.pass_clear = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  assign rd_idx = rd_idx_r;

  a_tick_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tick_accept |=> (state_r == S_SCAN))
    else $error("tick transaction did not start a scan");

  a_decide_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |=> (state_r == S_IDLE || state_r == S_SCAN))
    else $error("bad exit from decide");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state not one-hot");

endmodule

FILE: design/dtq_datapath.sv
`timescale 1ns / 1ps

module dtq_datapath import dtq_pkg::*; #(
  parameter int NUM_JOBS  = NUM_JOBS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  localparam int IDX_W = $clog2(NUM_JOBS),
  localparam int CNT_W = $clog2(NUM_JOBS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dtq_cmd_t          cmd,
  input  logic [IDX_W-1:0]  rd_idx,
  input  in_item_t          in_data,
  output dtq_status_t       status,
  output logic              out_valid,
  output out_item_t         out_data
);

  logic [NUM_JOBS-1:0]  valid_r, valid_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic                 cmp_en_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     best_r, best_nxt;
  logic [TIME_BITS-1:0] best_dl_r, best_dl_nxt;
  logic [CNT_W-1:0]     due_cnt_r, due_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 ram_we;
  logic [TIME_BITS-1:0] ram_rdata;
  logic                 id_in_range;
  logic [IDX_W-1:0]     id_idx;
  logic                 id_pending;
  logic                 due;
  logic                 better;

  assign id_in_range = 32'(in_data.job_id) < 32'(NUM_JOBS);
  assign id_idx      = IDX_W'(in_data.job_id);
  assign id_pending  = id_in_range && valid_r[id_idx];

  assign due    = cmp_en_r && valid_r[cmp_idx_r] && (ram_rdata <= now_r);
  assign better = !found_r || (ram_rdata < best_dl_r);

  dtq_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (NUM_JOBS)
  ) u_deadline_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (id_idx),
    .wdata (TIME_BITS'(in_data.deadline)),
    .re    (cmd.rd_en),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    valid_nxt     = valid_r;
    now_nxt       = now_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_dl_nxt   = best_dl_r;
    due_cnt_nxt   = due_cnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;

    if (cmd.accept) begin
      unique case (in_data.operation)
        OP_ADD: begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.event_id = in_data.job_id;
          out_data_nxt.is_last  = 1'b1;
          if (!id_in_range || id_pending) begin
            out_data_nxt.event_kind = KIND_BUSY;
          end else begin
            out_data_nxt.event_kind = KIND_ADDED;
            valid_nxt[id_idx]       = 1'b1;
            ram_we                  = 1'b1;
          end
        end
        OP_CANCEL: begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.event_id = in_data.job_id;
          out_data_nxt.is_last  = 1'b1;
          if (id_pending) begin
            out_data_nxt.event_kind = KIND_CANCELLED;
            valid_nxt[id_idx]       = 1'b0;
          end else begin
            out_data_nxt.event_kind = KIND_UNKNOWN;
          end
        end
        OP_TICK: begin
          now_nxt = TIME_BITS'(in_data.now_time);
        end
        default: begin
        end
      endcase
    end

    if (cmd.pass_clear) begin
      found_nxt   = 1'b0;
      due_cnt_nxt = '0;
    end else if (due) begin
      due_cnt_nxt = due_cnt_r + 1'b1;
      if (better) begin
        found_nxt   = 1'b1;
        best_nxt    = cmp_idx_r;
        best_dl_nxt = ram_rdata;
      end
    end

    if (cmd.fire) begin
      valid_nxt[best_r]       = 1'b0;
      out_valid_nxt           = 1'b1;
      out_data_nxt.event_kind = KIND_FIRED;
      out_data_nxt.event_id   = 4'(best_r);
      out_data_nxt.is_last    = (due_cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cmp_en_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      due_cnt_r   <= '0;
    end else begin
      valid_r     <= valid_nxt;
      cmp_en_r    <= cmd.rd_en;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      due_cnt_r   <= due_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    cmp_idx_r  <= rd_idx;
    best_r     <= best_nxt;
    best_dl_r  <= best_dl_nxt;
    out_data_r <= out_data_nxt;
  end

  assign status.found = found_r;
  assign status.last  = (due_cnt_r == CNT_W'(1));
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  a_fire_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fire |-> (found_r && valid_r[best_r]))
    else $error("fire without a pending due job");

  a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fire |=> !valid_r[$past(best_r)])
    else $error("fired job still pending");

  a_found_counts: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (due_cnt_r != '0))
    else $error("best entry without a due count");

endmodule
